### design/rta_pkg.sv
// shared types, constants and codes for the route table with aging
// no dependencies
package rta_pkg;
	localparam int TableEntriesDefault = 16;
	localparam int MaxUnreachableDefault = 16;
	localparam int ResultCap = 16;
	localparam logic [63:0] UsPerS = 64'd1000000;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0, OP_LOOKUP = 2'd1, OP_DELETE = 2'd2, OP_BREAK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		COND_ACTIVE = 2'd0, COND_IDLE = 2'd1, COND_EXPIRED = 2'd2, COND_BROKEN = 2'd3
	} cond_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_PRESENT = 3'd2, ST_FULL = 3'd3,
		ST_UNREACH = 3'd4, ST_NONE_UNREACH = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		REG_ACTIVE = 2'd0, REG_IDLE = 2'd1, REG_LIFETIME = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_AGE, S_WRITE, S_EMIT, S_ADD, S_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture input item, clear scan state
		logic read;      // read entry at index into stage register
		logic age;       // compute aged entry and decisions
		logic wr_aged;   // write back aged entry (may clear)
		logic wr_clear;  // clear the entry at index
		logic wr_break;  // mark the entry broken
		logic wr_add;    // write new route at free slot
		logic idx_inc;   // next index
		logic res_load;  // build result register
		logic [2:0] res_kind; // status for result
		logic res_last;
		logic res_found; // copy entry contents into result
		logic cnt_inc;   // count unreachable report
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic idx_end;   // index is the last entry
		logic match;     // key match after aging
		logic hop_match; // hop match after aging
		logic active;    // aged condition is active
		logic cnt_ok;    // below report cap
		logic any_rep;   // at least one report given
		logic free_ok;   // a free slot was seen
	} sts_t;
endpackage

### design/rta_datapath.sv
// datapath: entry store, aging arithmetic, key compare and result register
// depends on rta_pkg
module rta_datapath #(
	parameter int TABLE_ENTRIES = rta_pkg::TableEntriesDefault,
	parameter int MAX_UNREACHABLE = rta_pkg::MaxUnreachableDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  rta_pkg::cmd_t cmd,
	output rta_pkg::sts_t sts,
	input  logic cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [1:0] op,
	input  logic [47:0] now_us,
	input  logic [63:0] dest_addr_hi,
	input  logic [63:0] dest_addr_lo,
	input  logic [7:0] metric_kind,
	input  logic [63:0] hop_addr_hi,
	input  logic [63:0] hop_addr_lo,
	input  logic [15:0] seq_number,
	input  logic [7:0] metric_value,
	input  logic [1:0] route_condition,
	input  logic [47:0] used_at_us,
	input  logic [47:0] expires_at_us,
	output logic [2:0] status,
	output logic [63:0] out_dest_hi,
	output logic [63:0] out_dest_lo,
	output logic [63:0] out_hop_hi,
	output logic [63:0] out_hop_lo,
	output logic [15:0] out_seq,
	output logic [7:0] out_metric,
	output logic [1:0] out_condition,
	output logic [47:0] out_used_at,
	output logic [47:0] out_expires_at,
	output logic last
);
	import rta_pkg::*;
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CapN = (MAX_UNREACHABLE < ResultCap) ? MAX_UNREACHABLE : ResultCap;
	localparam int CW = $clog2(CapN + 1);

	logic [15:0] act_q, idl_q, life_q;
	logic [63:0] act_us_q, idl_us_q, life_us_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [63:0] dhi_m [TABLE_ENTRIES];
	logic [63:0] dlo_m [TABLE_ENTRIES];
	logic [63:0] hhi_m [TABLE_ENTRIES];
	logic [63:0] hlo_m [TABLE_ENTRIES];
	logic [7:0] kind_m [TABLE_ENTRIES];
	logic [15:0] seq_m [TABLE_ENTRIES];
	logic [7:0] met_m [TABLE_ENTRIES];
	logic [1:0] cond_m [TABLE_ENTRIES];
	logic [47:0] used_m [TABLE_ENTRIES];
	logic [47:0] exp_m [TABLE_ENTRIES];

	logic [1:0] op_q;
	logic [47:0] now_q, uin_q, ein_q;
	logic [63:0] dhi_q, dlo_q, hhi_q, hlo_q;
	logic [7:0] kind_q, mv_q;
	logic [15:0] sn_q;
	logic [1:0] rc_q;
	logic [IW-1:0] idx_q, free_q;
	logic free_ok_q;
	logic [CW-1:0] cnt_q;
	logic any_q;
	// report held until the next one shows whether it is the final one
	logic [63:0] rp_dhi_q, rp_dlo_q;
	logic [15:0] rp_seq_q;

	// stage 1: entry read
	logic v_s1;
	logic [63:0] dhi_s1, dlo_s1, hhi_s1, hlo_s1;
	logic [7:0] kind_s1, met_s1;
	logic [15:0] seq_s1;
	logic [1:0] cond_s1;
	logic [47:0] used_s1, exp_s1;
	// stage 2: aged entry
	logic v_s2;
	logic [1:0] cond_s2;
	logic [47:0] used_s2;
	logic match_s2, hmatch_s2;

	// config scaled to microseconds, one multiply per register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 16'd5;
			idl_q <= 16'd200;
			life_q <= 16'd300;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ACTIVE: act_q <= cfg_data;
				REG_IDLE: idl_q <= cfg_data;
				REG_LIFETIME: life_q <= cfg_data;
				default: ;
			endcase
		end
	end
	always_ff @(posedge clk) begin
		act_us_q <= {48'd0, act_q} * UsPerS;
		idl_us_q <= {48'd0, idl_q} * UsPerS;
		life_us_q <= {48'd0, life_q} * UsPerS;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op; now_q <= now_us; dhi_q <= dest_addr_hi; dlo_q <= dest_addr_lo;
			kind_q <= metric_kind; hhi_q <= hop_addr_hi; hlo_q <= hop_addr_lo;
			sn_q <= seq_number; mv_q <= metric_value; rc_q <= route_condition;
			uin_q <= used_at_us; ein_q <= expires_at_us;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			v_s1 <= valid_q[idx_q];
			dhi_s1 <= dhi_m[idx_q]; dlo_s1 <= dlo_m[idx_q];
			hhi_s1 <= hhi_m[idx_q]; hlo_s1 <= hlo_m[idx_q];
			kind_s1 <= kind_m[idx_q]; seq_s1 <= seq_m[idx_q]; met_s1 <= met_m[idx_q];
			cond_s1 <= cond_m[idx_q]; used_s1 <= used_m[idx_q]; exp_s1 <= exp_m[idx_q];
		end
	end

	logic [63:0] now64, used64;
	logic ages, t_act, t_idl, t_life;
	logic [1:0] cond_n;
	logic [47:0] used_n;
	logic v_n;
	always_comb begin
		now64 = {16'd0, now_q};
		used64 = {16'd0, used_s1};
		ages = v_s1 && (exp_s1 != 48'd0);
		t_act = now64 > used64 + act_us_q;
		t_idl = (now64 > used64 + idl_us_q) || (exp_s1 <= now_q);
		t_life = now64 >= used64 + life_us_q;
		cond_n = cond_s1;
		used_n = used_s1;
		v_n = v_s1;
		if (ages) begin
			if (cond_s1 == COND_ACTIVE && t_act) begin
				cond_n = COND_IDLE; used_n = now_q;
			end
			if (cond_s1 == COND_IDLE && t_idl) begin
				cond_n = COND_EXPIRED; used_n = now_q;
			end
			if (t_life) v_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.age) begin
			v_s2 <= v_n;
			cond_s2 <= v_n ? cond_n : COND_ACTIVE;
			used_s2 <= v_n ? used_n : 48'd0;
			match_s2 <= v_n && dhi_s1 == dhi_q && dlo_s1 == dlo_q && kind_s1 == kind_q;
			hmatch_s2 <= v_n && hhi_s1 == hhi_q && hlo_s1 == hlo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_add) begin
			valid_q[free_q] <= 1'b1;
		end else if (cmd.wr_clear) begin
			valid_q[idx_q] <= 1'b0;
		end else if (cmd.wr_aged) begin
			valid_q[idx_q] <= v_s2;
		end
	end

	// contents of entries that are not valid are never reported
	always_ff @(posedge clk) begin
		if (cmd.wr_add) begin
			dhi_m[free_q] <= dhi_q; dlo_m[free_q] <= dlo_q;
			hhi_m[free_q] <= hhi_q; hlo_m[free_q] <= hlo_q;
			kind_m[free_q] <= kind_q; seq_m[free_q] <= sn_q; met_m[free_q] <= mv_q;
			cond_m[free_q] <= rc_q; used_m[free_q] <= uin_q; exp_m[free_q] <= ein_q;
		end else if (cmd.wr_clear || (cmd.wr_aged && !v_s2)) begin
			dhi_m[idx_q] <= '0; dlo_m[idx_q] <= '0; hhi_m[idx_q] <= '0; hlo_m[idx_q] <= '0;
			kind_m[idx_q] <= '0; seq_m[idx_q] <= '0; met_m[idx_q] <= '0;
			cond_m[idx_q] <= COND_ACTIVE; used_m[idx_q] <= '0; exp_m[idx_q] <= '0;
		end else if (cmd.wr_aged) begin
			cond_m[idx_q] <= cmd.wr_break ? COND_BROKEN : cond_s2;
			used_m[idx_q] <= used_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0; free_q <= '0; free_ok_q <= 1'b0; cnt_q <= '0; any_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q <= '0; free_q <= '0; free_ok_q <= 1'b0; cnt_q <= '0; any_q <= 1'b0;
		end else begin
			if (cmd.wr_aged && !v_s2 && !free_ok_q) begin
				free_q <= idx_q; free_ok_q <= 1'b1;
			end
			if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1; any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt_inc) begin
			rp_dhi_q <= dhi_s1; rp_dlo_q <= dlo_s1; rp_seq_q <= seq_s1;
		end
	end

	always_comb begin
		sts.op = op_q;
		sts.idx_end = (idx_q == IW'(TABLE_ENTRIES - 1));
		sts.match = match_s2;
		sts.hop_match = hmatch_s2;
		sts.active = cond_s2 == COND_ACTIVE;
		sts.cnt_ok = cnt_q < CW'(CapN);
		sts.any_rep = any_q;
		sts.free_ok = free_ok_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status <= cmd.res_kind;
			last <= cmd.res_last;
			out_dest_hi <= '0; out_dest_lo <= '0; out_hop_hi <= '0; out_hop_lo <= '0;
			out_seq <= '0; out_metric <= '0; out_condition <= '0;
			out_used_at <= '0; out_expires_at <= '0;
			if (cmd.res_found) begin
				out_dest_hi <= dhi_s1; out_dest_lo <= dlo_s1;
				out_hop_hi <= hhi_s1; out_hop_lo <= hlo_s1;
				out_seq <= seq_s1; out_metric <= met_s1; out_condition <= cond_s2;
				out_used_at <= used_s2; out_expires_at <= exp_s1;
			end else if (cmd.res_kind == ST_UNREACH) begin
				out_dest_hi <= rp_dhi_q; out_dest_lo <= rp_dlo_q; out_seq <= rp_seq_q;
			end
		end
	end
endmodule

### design/rta_ctrl.sv
// controller state machine: scan sequencing and result handshake
// depends on rta_pkg
module rta_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  rta_pkg::sts_t sts,
	output rta_pkg::cmd_t cmd
);
	import rta_pkg::*;
	state_t state_q, state_n;
	logic ov_q, ov_n;
	logic slot_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ov_q <= 1'b0;
		end else begin
			state_q <= state_n; ov_q <= ov_n;
		end
	end
	assign out_valid = ov_q;
	assign slot_ok = !ov_q || out_ready;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		ov_n = ov_q && !out_ready;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1; state_n = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1; state_n = S_AGE;
			end
			S_AGE: begin
				cmd.age = 1'b1; state_n = S_WRITE;
			end
			S_WRITE: begin
				if (sts.op == OP_BREAK) begin
					if (sts.hop_match && sts.active && sts.cnt_ok) begin
						state_n = S_EMIT;
					end else begin
						cmd.wr_aged = 1'b1; cmd.wr_break = sts.hop_match;
						if (sts.idx_end) state_n = S_DONE;
						else begin
							cmd.idx_inc = 1'b1; state_n = S_READ;
						end
					end
				end else if (sts.match) begin
					if (slot_ok) begin
						cmd.wr_aged = 1'b1;
						cmd.wr_clear = sts.op == OP_DELETE;
						cmd.res_load = 1'b1; cmd.res_last = 1'b1;
						cmd.res_found = sts.op == OP_LOOKUP;
						cmd.res_kind = (sts.op == OP_ADD) ? ST_PRESENT : ST_OK;
						ov_n = 1'b1; state_n = S_IDLE;
					end
				end else begin
					cmd.wr_aged = 1'b1;
					if (sts.idx_end) state_n = S_DONE;
					else begin
						cmd.idx_inc = 1'b1; state_n = S_READ;
					end
				end
			end
			S_EMIT: begin
				// the held report goes out once the next one is known
				if (!sts.any_rep || slot_ok) begin
					if (sts.any_rep) begin
						cmd.res_load = 1'b1; cmd.res_kind = ST_UNREACH;
						ov_n = 1'b1;
					end
					cmd.cnt_inc = 1'b1;
					cmd.wr_aged = 1'b1; cmd.wr_break = 1'b1;
					if (sts.idx_end) state_n = S_DONE;
					else begin
						cmd.idx_inc = 1'b1; state_n = S_READ;
					end
				end
			end
			S_DONE: begin
				if (slot_ok) begin
					if (sts.op == OP_BREAK) begin
						cmd.res_load = 1'b1; cmd.res_last = 1'b1;
						cmd.res_kind = sts.any_rep ? ST_UNREACH : ST_NONE_UNREACH;
						ov_n = 1'b1; state_n = S_IDLE;
					end else if (sts.op == OP_ADD) begin
						state_n = S_ADD;
					end else begin
						cmd.res_load = 1'b1; cmd.res_last = 1'b1; cmd.res_kind = ST_NOT_FOUND;
						ov_n = 1'b1; state_n = S_IDLE;
					end
				end
			end
			S_ADD: begin
				if (slot_ok) begin
					cmd.res_load = 1'b1; cmd.res_last = 1'b1;
					cmd.res_kind = sts.free_ok ? ST_OK : ST_FULL;
					cmd.wr_add = sts.free_ok;
					ov_n = 1'b1; state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end
endmodule

### design/route_table_with_aging.sv
// top level of the route table with aging: controller plus datapath
// depends on rta_pkg, rta_ctrl, rta_datapath
// each entry scanned is read, aged and written back in turn; a lookup or delete hit gives
// its result at the matching entry's write-back, a miss from S_DONE after the last entry,
// an add stores from S_ADD; a break emits from S_EMIT, ends in S_DONE; output stalls hold;
// one item at a time, the next accepted in the cycle after the final result is loaded
// reset clears all entries at once through valid flip-flops and loads register defaults
module route_table_with_aging #(
	parameter int TABLE_ENTRIES = rta_pkg::TableEntriesDefault,
	parameter int MAX_UNREACHABLE = rta_pkg::MaxUnreachableDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] op,
	input  logic [47:0] now_us,
	input  logic [63:0] dest_addr_hi,
	input  logic [63:0] dest_addr_lo,
	input  logic [7:0] metric_kind,
	input  logic [63:0] hop_addr_hi,
	input  logic [63:0] hop_addr_lo,
	input  logic [15:0] seq_number,
	input  logic [7:0] metric_value,
	input  logic [1:0] route_condition,
	input  logic [47:0] used_at_us,
	input  logic [47:0] expires_at_us,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] status,
	output logic [63:0] out_dest_hi,
	output logic [63:0] out_dest_lo,
	output logic [63:0] out_hop_hi,
	output logic [63:0] out_hop_lo,
	output logic [15:0] out_seq,
	output logic [7:0] out_metric,
	output logic [1:0] out_condition,
	output logic [47:0] out_used_at,
	output logic [47:0] out_expires_at,
	output logic last
);
	import rta_pkg::*;
	cmd_t cmd;
	sts_t sts;
	assign cfg_ready = 1'b1;

	rta_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	rta_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_UNREACHABLE(MAX_UNREACHABLE)) u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_valid, .cfg_index, .cfg_data,
		.op, .now_us, .dest_addr_hi, .dest_addr_lo, .metric_kind, .hop_addr_hi, .hop_addr_lo,
		.seq_number, .metric_value, .route_condition, .used_at_us, .expires_at_us,
		.status, .out_dest_hi, .out_dest_lo, .out_hop_hi, .out_hop_lo, .out_seq,
		.out_metric, .out_condition, .out_used_at, .out_expires_at, .last
	);

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> in_valid && in_ready)
		else $error("load without accepted item");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
		else $error("result dropped");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_add && cmd.wr_aged))
		else $error("two writes at once");
endmodule
